[design/dht_rx_pkg.sv]
// dht_rx_pkg: types and constants of the single-wire frame receiver
// payload structs, register indexes, reset values and error codes
// no dependencies
package dht_rx_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned WIDTH_W   = 8;
  localparam int unsigned BIT_IDX_W = 6;
  localparam int unsigned FRAME_W   = 40;   // five bytes are reported
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_LOW   = 2'd1,
    ERR_NO_HIGH  = 2'd2,
    ERR_BAD_WIDTH = 2'd3
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LOW_TIME   = 3'd0,
    CFG_LOW_CHECK_DELAY  = 3'd1,
    CFG_HIGH_CHECK_DELAY = 3'd2,
    CFG_SHORT_LIMIT      = 3'd3,
    CFG_ZERO_LIMIT       = 3'd4,
    CFG_ONE_FLOOR        = 3'd5,
    CFG_LONG_LIMIT       = 3'd6
  } cfg_idx_t;

  localparam logic [TICK_W-1:0]  RST_START_LOW_TIME   = 16'd18000;
  localparam logic [BYTE_W-1:0]  RST_LOW_CHECK_DELAY  = 8'd60;
  localparam logic [BYTE_W-1:0]  RST_HIGH_CHECK_DELAY = 8'd80;
  localparam logic [BYTE_W-1:0]  RST_SHORT_LIMIT      = 8'd13;
  localparam logic [BYTE_W-1:0]  RST_ZERO_LIMIT       = 8'd35;
  localparam logic [BYTE_W-1:0]  RST_ONE_FLOOR        = 8'd60;
  localparam logic [BYTE_W-1:0]  RST_LONG_LIMIT       = 8'd80;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = 8'd255;

  typedef struct packed {
    logic start_req;
    logic line_level;
  } in_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        error_code;
    logic [BYTE_W-1:0] humidity;
    logic [BYTE_W-1:0] humidity_fraction;
    logic [BYTE_W-1:0] temperature;
    logic [BYTE_W-1:0] temperature_fraction;
    logic [BYTE_W-1:0] checksum;
  } out_t;

endpackage

[design/dht11_frame_receiver_unit.sv]
// dht11_frame_receiver_unit: single-wire sensor frame receiver, one transfer per tick
// depends on dht_rx_pkg (payload structs, register indexes, error codes)
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in_     | input     | in_valid / in_ready  | dht_rx_pkg::in_t  (one tick)
//  out_    | output    | out_valid / out_ready| dht_rx_pkg::out_t (one result)
//  cfg_    | input     | cfg_we, no wait      | cfg_index, cfg_wdata
//
// every accepted tick gives exactly one result; it passes the input register and
// then the result register, and a stalled result can hold it in between
// a new tick may be accepted each cycle while no result stalls; the rate is
// set by the tick state update, combinational between the input and result registers
// reset (rst_n low, synchronous) clears both valid flags, the phase and counters,
// the frame bits and loads the register defaults
// a stalled result holds in the output register; the input register then
// holds its tick and in_ready falls until out_ready returns
module dht11_frame_receiver_unit #(
  parameter int unsigned FRAME_BITS = 40
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  dht_rx_pkg::in_t                        in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output dht_rx_pkg::out_t                       out_data,
  input  logic                                   cfg_we,
  input  logic [dht_rx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dht_rx_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // last bit index as a sum of bit_idx + 1, one bit wider than the index
  localparam logic [dht_rx_pkg::BIT_IDX_W:0] LAST_COUNT =
    (dht_rx_pkg::BIT_IDX_W+1)'(FRAME_BITS);

  // one-hot receive phases
  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_DRIVE   = 7'b0000010,
    PH_LOWCHK  = 7'b0000100,
    PH_HIGHCHK = 7'b0001000,
    PH_FALL    = 7'b0010000,
    PH_RISE    = 7'b0100000,
    PH_HIGH    = 7'b1000000
  } phase_t;

  // configuration registers
  logic [dht_rx_pkg::TICK_W-1:0] start_low_time_r;
  logic [dht_rx_pkg::BYTE_W-1:0] low_check_delay_r;
  logic [dht_rx_pkg::BYTE_W-1:0] high_check_delay_r;
  logic [dht_rx_pkg::BYTE_W-1:0] short_limit_r;
  logic [dht_rx_pkg::BYTE_W-1:0] zero_limit_r;
  logic [dht_rx_pkg::BYTE_W-1:0] one_floor_r;
  logic [dht_rx_pkg::BYTE_W-1:0] long_limit_r;

  // input stage
  logic            in_valid_r;
  dht_rx_pkg::in_t in_r;

  // receiver state
  phase_t                           phase_r,     phase_nxt;
  logic [dht_rx_pkg::TICK_W-1:0]    tick_cnt_r,  tick_cnt_nxt;
  logic [dht_rx_pkg::WIDTH_W-1:0]   width_cnt_r, width_cnt_nxt;
  logic [dht_rx_pkg::BIT_IDX_W-1:0] bit_idx_r,   bit_idx_nxt;
  logic [dht_rx_pkg::FRAME_W-1:0]   frame_r,     frame_nxt;

  // result stage
  logic             out_valid_r;
  dht_rx_pkg::out_t out_r, out_nxt;

  logic advance;

  // the state moves when the input stage hands its tick to the result stage
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration writes; user issues them only with no tick in flight, not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_low_time_r   <= dht_rx_pkg::RST_START_LOW_TIME;
      low_check_delay_r  <= dht_rx_pkg::RST_LOW_CHECK_DELAY;
      high_check_delay_r <= dht_rx_pkg::RST_HIGH_CHECK_DELAY;
      short_limit_r      <= dht_rx_pkg::RST_SHORT_LIMIT;
      zero_limit_r       <= dht_rx_pkg::RST_ZERO_LIMIT;
      one_floor_r        <= dht_rx_pkg::RST_ONE_FLOOR;
      long_limit_r       <= dht_rx_pkg::RST_LONG_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        dht_rx_pkg::CFG_START_LOW_TIME:   start_low_time_r   <= cfg_wdata;
        dht_rx_pkg::CFG_LOW_CHECK_DELAY:  low_check_delay_r  <= cfg_wdata[7:0];
        dht_rx_pkg::CFG_HIGH_CHECK_DELAY: high_check_delay_r <= cfg_wdata[7:0];
        dht_rx_pkg::CFG_SHORT_LIMIT:      short_limit_r      <= cfg_wdata[7:0];
        dht_rx_pkg::CFG_ZERO_LIMIT:       zero_limit_r       <= cfg_wdata[7:0];
        dht_rx_pkg::CFG_ONE_FLOOR:        one_floor_r        <= cfg_wdata[7:0];
        dht_rx_pkg::CFG_LONG_LIMIT:       long_limit_r       <= cfg_wdata[7:0];
        default: begin
          // unused index, write is dropped
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // one tick of the receiver
  always_comb begin
    logic                                line;
    logic                                drive;
    logic                                done;
    dht_rx_pkg::err_t                    err;
    logic [dht_rx_pkg::BIT_IDX_W:0]      idx_inc;
    logic                                report;

    line          = in_r.line_level;
    drive         = 1'b0;
    done          = 1'b0;
    err           = dht_rx_pkg::ERR_NONE;
    idx_inc       = {1'b0, bit_idx_r} + 1'b1;
    phase_nxt     = phase_r;
    tick_cnt_nxt  = tick_cnt_r;
    width_cnt_nxt = width_cnt_r;
    bit_idx_nxt   = bit_idx_r;
    frame_nxt     = frame_r;

    // a start request aborts whatever is running
    if (in_r.start_req) begin
      phase_nxt    = PH_DRIVE;
      tick_cnt_nxt = '0;
    end

    case (phase_nxt)
      PH_DRIVE: begin
        if (tick_cnt_nxt >= start_low_time_r) begin
          phase_nxt    = PH_LOWCHK;
          tick_cnt_nxt = '0;
        end else begin
          drive        = 1'b1;
          tick_cnt_nxt = tick_cnt_nxt + 1'b1;
        end
      end
      PH_LOWCHK: begin
        if (tick_cnt_nxt >= {8'd0, low_check_delay_r}) begin
          tick_cnt_nxt = '0;
          if (line) begin
            done      = 1'b1;
            err       = dht_rx_pkg::ERR_NO_LOW;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_HIGHCHK;
          end
        end else begin
          tick_cnt_nxt = tick_cnt_nxt + 1'b1;
        end
      end
      PH_HIGHCHK: begin
        if (tick_cnt_nxt >= {8'd0, high_check_delay_r}) begin
          tick_cnt_nxt = '0;
          if (!line) begin
            done      = 1'b1;
            err       = dht_rx_pkg::ERR_NO_HIGH;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_FALL;
          end
        end else begin
          tick_cnt_nxt = tick_cnt_nxt + 1'b1;
        end
      end
      PH_FALL: begin
        // sensor pulls low ahead of the first bit
        if (!line) begin
          phase_nxt   = PH_RISE;
          bit_idx_nxt = '0;
        end
      end
      PH_RISE: begin
        if (line) begin
          phase_nxt     = PH_HIGH;
          width_cnt_nxt = 8'd1;
        end
      end
      PH_HIGH: begin
        if (line) begin
          if (width_cnt_r != dht_rx_pkg::WIDTH_MAX) begin
            width_cnt_nxt = width_cnt_r + 1'b1;
          end
        end else if (width_cnt_r <= short_limit_r || width_cnt_r >= long_limit_r) begin
          done      = 1'b1;
          err       = dht_rx_pkg::ERR_BAD_WIDTH;
          phase_nxt = PH_IDLE;
        end else begin
          // width in the gap between windows keeps the old bit; a one wins an overlap
          for (int j = 0; j < int'(dht_rx_pkg::FRAME_W); j++) begin
            if (bit_idx_r == (dht_rx_pkg::BIT_IDX_W)'(dht_rx_pkg::FRAME_W - 1 - j)) begin
              if (width_cnt_r < zero_limit_r) begin
                frame_nxt[j] = 1'b0;
              end
              if (width_cnt_r > one_floor_r) begin
                frame_nxt[j] = 1'b1;
              end
            end
          end
          if (idx_inc >= LAST_COUNT) begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            bit_idx_nxt = idx_inc[dht_rx_pkg::BIT_IDX_W-1:0];
            phase_nxt   = PH_RISE;
          end
        end
      end
      PH_IDLE: begin
        // waiting for a start request
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    report = done && (err == dht_rx_pkg::ERR_NONE);

    out_nxt.drive_low            = drive;
    out_nxt.busy_res             = (phase_nxt != PH_IDLE);
    out_nxt.done_res             = done;
    out_nxt.error_code           = err;
    out_nxt.humidity             = report ? frame_r[39:32] : '0;
    out_nxt.humidity_fraction    = report ? frame_nxt[31:24] : '0;
    out_nxt.temperature          = report ? frame_nxt[23:16] : '0;
    out_nxt.temperature_fraction = report ? frame_nxt[15:8] : '0;
    out_nxt.checksum             = report ? frame_nxt[7:0] : '0;
    // first byte may also be written by the last bit when the frame is short
    if (report) begin
      out_nxt.humidity = frame_nxt[39:32];
    end
  end

  // receiver state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_cnt_r  <= '0;
      width_cnt_r <= '0;
      bit_idx_r   <= '0;
      frame_r     <= '0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      width_cnt_r <= width_cnt_nxt;
      bit_idx_r   <= bit_idx_nxt;
      frame_r     <= frame_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  // a finished read is never still busy
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.done_res |-> !out_r.busy_res)
    else $error("done result reports busy");

  // an error code only comes with the end of a read
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.error_code != dht_rx_pkg::ERR_NONE) |-> out_r.done_res)
    else $error("error code without done");

  // the line is only driven while a read is under way
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.drive_low |-> out_r.busy_res && !out_r.done_res)
    else $error("line driven outside a read");

  // an advance always leaves a result waiting in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result lost after advance");
`endif

endmodule
